// ===== rtl/hsv2rgb_pkg.sv =====
`default_nettype none
package hsv2rgb_pkg;

    localparam int HUE_W  = 15;
    localparam int FRAC_W = 16;
    localparam int CH_W   = 8;
    localparam int SPAN_W = 12;
    localparam int WT_W   = 27;
    localparam int PROD_W = 42;
    localparam int SUM_W  = PROD_W + 4;

    localparam logic [HUE_W-1:0]  HUE_MAX      = 15'd23040;
    localparam logic [HUE_W-1:0]  SECTOR_UNITS = 15'd3840;
    localparam logic [FRAC_W-1:0] Q15_ONE      = 16'd32768;
    // 1.0 in the weight scale: 2^15 * 3840
    localparam logic [WT_W:0]     WT_FULL      = 28'd125829120;

    typedef enum logic [2:0] {
        SEC_RED_YEL = 3'd0,
        SEC_YEL_GRN = 3'd1,
        SEC_GRN_CYN = 3'd2,
        SEC_CYN_BLU = 3'd3,
        SEC_BLU_MAG = 3'd4,
        SEC_MAG_RED = 3'd5,
        SEC_WRAP    = 3'd6
    } sector_t;

    typedef struct packed {
        sector_t             sector;
        logic [SPAN_W-1:0]   span;
        logic [FRAC_W-1:0]   sat;
        logic [FRAC_W-1:0]   val;
    } hue_data_t;

    typedef struct packed {
        sector_t             sector;
        logic [FRAC_W-1:0]   val;
        logic [WT_W-1:0]     wt_x;
        logic [WT_W-1:0]     wt_zero;
    } wt_data_t;

    typedef struct packed {
        logic [PROD_W-1:0]   prod_r;
        logic [PROD_W-1:0]   prod_g;
        logic [PROD_W-1:0]   prod_b;
    } prod_data_t;

endpackage
`default_nettype wire

// ===== rtl/hsv2rgb_hsv_if.sv =====
`default_nettype none
interface hsv2rgb_hsv_if;
    logic                              valid;
    logic                              ready;
    logic [hsv2rgb_pkg::HUE_W-1:0]     hue;
    logic [hsv2rgb_pkg::FRAC_W-1:0]    saturation;
    logic [hsv2rgb_pkg::FRAC_W-1:0]    brightness;

    modport source (output valid, hue, saturation, brightness, input ready);
    modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface
`default_nettype wire

// ===== rtl/hsv2rgb_rgb_if.sv =====
`default_nettype none
interface hsv2rgb_rgb_if;
    logic                            valid;
    logic                            ready;
    logic [hsv2rgb_pkg::CH_W-1:0]    red;
    logic [hsv2rgb_pkg::CH_W-1:0]    green;
    logic [hsv2rgb_pkg::CH_W-1:0]    blue;

    modport source (output valid, red, green, blue, input ready);
    modport sink   (input valid, red, green, blue, output ready);
endinterface
`default_nettype wire

// ===== rtl/hsv2rgb_hue_stage.sv =====
`default_nettype none
module hsv2rgb_hue_stage (
    input  wire logic               clk,
    input  wire logic               rst_n,
    hsv2rgb_hsv_if.sink             hsv,
    output logic                    valid,
    input  wire logic               ready,
    output hsv2rgb_pkg::hue_data_t  data
);

    logic                   valid_reg;
    hsv2rgb_pkg::hue_data_t data_reg;
    hsv2rgb_pkg::hue_data_t data_next;
    logic [hsv2rgb_pkg::HUE_W-1:0] hue_sat;
    logic [hsv2rgb_pkg::HUE_W-1:0] pos;

    assign hsv.ready = !valid_reg || ready;
    assign valid     = valid_reg;
    assign data      = data_reg;

    always_comb
    begin
        hue_sat = (hsv.hue > hsv2rgb_pkg::HUE_MAX) ? hsv2rgb_pkg::HUE_MAX : hsv.hue;

        if (hue_sat >= 15'd23040)
            data_next.sector = hsv2rgb_pkg::SEC_WRAP;
        else if (hue_sat >= 15'd19200)
            data_next.sector = hsv2rgb_pkg::SEC_MAG_RED;
        else if (hue_sat >= 15'd15360)
            data_next.sector = hsv2rgb_pkg::SEC_BLU_MAG;
        else if (hue_sat >= 15'd11520)
            data_next.sector = hsv2rgb_pkg::SEC_CYN_BLU;
        else if (hue_sat >= 15'd7680)
            data_next.sector = hsv2rgb_pkg::SEC_GRN_CYN;
        else if (hue_sat >= 15'd3840)
            data_next.sector = hsv2rgb_pkg::SEC_YEL_GRN;
        else
            data_next.sector = hsv2rgb_pkg::SEC_RED_YEL;

        // position within a pair of sectors
        if (hue_sat >= 15'd23040)
            pos = hue_sat - 15'd23040;
        else if (hue_sat >= 15'd15360)
            pos = hue_sat - 15'd15360;
        else if (hue_sat >= 15'd7680)
            pos = hue_sat - 15'd7680;
        else
            pos = hue_sat;

        if (pos >= hsv2rgb_pkg::SECTOR_UNITS)
            data_next.span = hsv2rgb_pkg::SPAN_W'(pos - hsv2rgb_pkg::SECTOR_UNITS);
        else
            data_next.span = hsv2rgb_pkg::SPAN_W'(hsv2rgb_pkg::SECTOR_UNITS - pos);

        data_next.sat = (hsv.saturation > hsv2rgb_pkg::Q15_ONE) ?
                        hsv2rgb_pkg::Q15_ONE : hsv.saturation;
        data_next.val = (hsv.brightness > hsv2rgb_pkg::Q15_ONE) ?
                        hsv2rgb_pkg::Q15_ONE : hsv.brightness;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (hsv.ready)
            valid_reg <= hsv.valid;
    end

    always_ff @(posedge clk)
    begin
        if (hsv.ready && hsv.valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_weight_stage.sv =====
`default_nettype none
module hsv2rgb_weight_stage (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire hsv2rgb_pkg::hue_data_t  in_data,
    output logic                         valid,
    input  wire logic                    ready,
    output hsv2rgb_pkg::wt_data_t        data
);

    logic                  valid_reg;
    hsv2rgb_pkg::wt_data_t data_reg;
    hsv2rgb_pkg::wt_data_t data_next;
    logic [hsv2rgb_pkg::WT_W:0] sat_span;
    logic [hsv2rgb_pkg::WT_W:0] sat_full;
    logic [hsv2rgb_pkg::WT_W:0] wt_x_full;
    logic [hsv2rgb_pkg::WT_W:0] wt_zero_full;

    assign in_ready = !valid_reg || ready;
    assign valid    = valid_reg;
    assign data     = data_reg;

    // weight of each channel term after adding value minus chroma
    always_comb
    begin
        sat_span     = {12'd0, in_data.sat} * {16'd0, in_data.span};
        sat_full     = {12'd0, in_data.sat} * 28'd3840;
        wt_x_full    = hsv2rgb_pkg::WT_FULL - sat_span;
        wt_zero_full = hsv2rgb_pkg::WT_FULL - sat_full;

        data_next.sector  = in_data.sector;
        data_next.val     = in_data.val;
        data_next.wt_x    = wt_x_full[hsv2rgb_pkg::WT_W-1:0];
        data_next.wt_zero = wt_zero_full[hsv2rgb_pkg::WT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_mult_stage.sv =====
`default_nettype none
module hsv2rgb_mult_stage (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire hsv2rgb_pkg::wt_data_t  in_data,
    output logic                        valid,
    input  wire logic                   ready,
    output hsv2rgb_pkg::prod_data_t     data
);

    logic                    valid_reg;
    hsv2rgb_pkg::prod_data_t data_reg;
    hsv2rgb_pkg::prod_data_t data_next;
    logic [hsv2rgb_pkg::WT_W-1:0]   wt_full;
    logic [hsv2rgb_pkg::WT_W-1:0]   wt_r;
    logic [hsv2rgb_pkg::WT_W-1:0]   wt_g;
    logic [hsv2rgb_pkg::WT_W-1:0]   wt_b;
    logic [hsv2rgb_pkg::PROD_W:0]   prod_r;
    logic [hsv2rgb_pkg::PROD_W:0]   prod_g;
    logic [hsv2rgb_pkg::PROD_W:0]   prod_b;

    assign in_ready = !valid_reg || ready;
    assign valid    = valid_reg;
    assign data     = data_reg;

    always_comb
    begin
        wt_full = hsv2rgb_pkg::WT_FULL[hsv2rgb_pkg::WT_W-1:0];

        unique case (in_data.sector)
            hsv2rgb_pkg::SEC_RED_YEL:
            begin
                wt_r = wt_full;         wt_g = in_data.wt_x;    wt_b = in_data.wt_zero;
            end
            hsv2rgb_pkg::SEC_YEL_GRN:
            begin
                wt_r = in_data.wt_x;    wt_g = wt_full;         wt_b = in_data.wt_zero;
            end
            hsv2rgb_pkg::SEC_GRN_CYN:
            begin
                wt_r = in_data.wt_zero; wt_g = wt_full;         wt_b = in_data.wt_x;
            end
            hsv2rgb_pkg::SEC_CYN_BLU:
            begin
                wt_r = in_data.wt_zero; wt_g = in_data.wt_x;    wt_b = wt_full;
            end
            hsv2rgb_pkg::SEC_BLU_MAG:
            begin
                wt_r = in_data.wt_x;    wt_g = in_data.wt_zero; wt_b = wt_full;
            end
            default:
            begin
                // magenta-red sector and the 360 degree wrap
                wt_r = wt_full;         wt_g = in_data.wt_zero; wt_b = in_data.wt_x;
            end
        endcase

        prod_r = {27'd0, in_data.val} * {16'd0, wt_r};
        prod_g = {27'd0, in_data.val} * {16'd0, wt_g};
        prod_b = {27'd0, in_data.val} * {16'd0, wt_b};

        data_next.prod_r = prod_r[hsv2rgb_pkg::PROD_W-1:0];
        data_next.prod_g = prod_g[hsv2rgb_pkg::PROD_W-1:0];
        data_next.prod_b = prod_b[hsv2rgb_pkg::PROD_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_scale_stage.sv =====
`default_nettype none
module hsv2rgb_scale_stage (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire hsv2rgb_pkg::prod_data_t  in_data,
    hsv2rgb_rgb_if.source                 rgb
);

    logic                          valid_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]  red_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]  green_reg;
    logic [hsv2rgb_pkg::CH_W-1:0]  blue_reg;
    logic [hsv2rgb_pkg::SUM_W-1:0] sum_r;
    logic [hsv2rgb_pkg::SUM_W-1:0] sum_g;
    logic [hsv2rgb_pkg::SUM_W-1:0] sum_b;

    assign in_ready  = !valid_reg || rgb.ready;
    assign rgb.valid = valid_reg;
    assign rgb.red   = red_reg;
    assign rgb.green = green_reg;
    assign rgb.blue  = blue_reg;

    // 255 / (2^30 * 3840) reduces to 17 / 2^38: shift-add then take the top byte
    always_comb
    begin
        sum_r = {in_data.prod_r, 4'd0} + {4'd0, in_data.prod_r};
        sum_g = {in_data.prod_g, 4'd0} + {4'd0, in_data.prod_g};
        sum_b = {in_data.prod_b, 4'd0} + {4'd0, in_data.prod_b};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            red_reg   <= sum_r[45:38];
            green_reg <= sum_g[45:38];
            blue_reg  <= sum_b[45:38];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/hsv2rgb_to_rgb_convert.sv =====
`default_nettype none
// hsv to rgb pixel converter, four register stages
// throughput: one pixel per clock; stalls back up through per-stage valid/ready
// stages: hue sector decode, weight multiply, value multiply, scale to 8 bits
// reset: rst_n asynchronously clears every stage valid bit; data registers are not reset
module hsv_to_rgb_convert (
    input  wire logic      clk,
    input  wire logic      rst_n,
    hsv2rgb_hsv_if.sink    hsv,
    hsv2rgb_rgb_if.source  rgb
);

    logic                     s1_valid;
    logic                     s1_ready;
    hsv2rgb_pkg::hue_data_t   s1_data;
    logic                     s2_valid;
    logic                     s2_ready;
    hsv2rgb_pkg::wt_data_t    s2_data;
    logic                     s3_valid;
    logic                     s3_ready;
    hsv2rgb_pkg::prod_data_t  s3_data;

    hsv2rgb_hue_stage u_hue (
        .clk   (clk),
        .rst_n (rst_n),
        .hsv   (hsv),
        .valid (s1_valid),
        .ready (s1_ready),
        .data  (s1_data)
    );

    hsv2rgb_weight_stage u_weight (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s1_valid),
        .in_ready (s1_ready),
        .in_data  (s1_data),
        .valid    (s2_valid),
        .ready    (s2_ready),
        .data     (s2_data)
    );

    hsv2rgb_mult_stage u_mult (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s2_valid),
        .in_ready (s2_ready),
        .in_data  (s2_data),
        .valid    (s3_valid),
        .ready    (s3_ready),
        .data     (s3_data)
    );

    hsv2rgb_scale_stage u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s3_valid),
        .in_ready (s3_ready),
        .in_data  (s3_data),
        .rgb      (rgb)
    );

    // a full pipeline with a stalled output cannot take a new transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (rgb.valid && !rgb.ready && s1_valid && s2_valid && s3_valid) |-> !hsv.ready)
    else $error("input ready while pipeline full and stalled");

    // an item leaving the first stage lands in the second
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && s1_ready) |=> s2_valid)
    else $error("item lost between hue and weight stages");

    // output valid only rises after the multiply stage held an item
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rgb.valid) |-> $past(s3_valid))
    else $error("output valid without an item in flight");

endmodule
`default_nettype wire
